FILE: rtl/pip_pkg.sv
// Shared types and constants for the point-in-polygon ray casting block.
`timescale 1ns / 1ps

package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int ADDR_W       = 6;   // vertex table address bits
  localparam int CNT_W        = 7;   // vertex_count and crossings width
  localparam int COORD_W      = 32;

  // item command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic signed [COORD_W-1:0]   coord_t;
  typedef logic signed [COORD_W:0]     diff_t;   // difference of two coordinates
  typedef logic signed [2*COORD_W+1:0] prod_t;   // product of two differences
  typedef logic [CNT_W-1:0]            count_t;
  typedef logic [ADDR_W-1:0]           addr_t;

endpackage

FILE: rtl/pip_edge.sv
// Pipelined crossing test of one polygon edge against the query point.
`timescale 1ns / 1ps

module pip_edge import pip_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   edge_valid,
  input  coord_t x1,
  input  coord_t y1,
  input  coord_t x2,
  input  coord_t y2,
  input  coord_t px,
  input  coord_t py,
  output logic   hit_valid,
  output logic   hit,
  output logic   busy
);

  coord_t ylo, yhi, xhi;
  logic   pre;

  // stage 2: range checks and differences
  logic   s2_valid, s2_pre, s2_vert, s2_up;
  diff_t  s2_a, s2_b, s2_c, s2_d;

  // stage 3: cross products
  logic   s3_valid, s3_pre, s3_vert, s3_up;
  prod_t  s3_l, s3_r;

  always_comb begin
    ylo = (y1 < y2) ? y1 : y2;
    yhi = (y1 < y2) ? y2 : y1;
    xhi = (x1 < x2) ? x2 : x1;
    pre = (py > ylo) && (py <= yhi) && (px <= xhi) && (y1 != y2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= edge_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_pre  <= pre;
    s2_vert <= (x1 == x2);
    s2_up   <= (y2 > y1);
    s2_a    <= diff_t'({px[COORD_W-1], px}) - diff_t'({x1[COORD_W-1], x1});
    s2_b    <= diff_t'({y2[COORD_W-1], y2}) - diff_t'({y1[COORD_W-1], y1});
    s2_c    <= diff_t'({py[COORD_W-1], py}) - diff_t'({y1[COORD_W-1], y1});
    s2_d    <= diff_t'({x2[COORD_W-1], x2}) - diff_t'({x1[COORD_W-1], x1});

    s3_pre  <= s2_pre;
    s3_vert <= s2_vert;
    s3_up   <= s2_up;
    s3_l    <= s2_a * s2_b;   // (px-x1)*(y2-y1)
    s3_r    <= s2_c * s2_d;   // (py-y1)*(x2-x1)
  end

  // comparison direction flips with the sign of y2-y1
  assign hit_valid = s3_valid;
  assign hit       = s3_pre && (s3_vert || (s3_up ? (s3_l <= s3_r) : (s3_l >= s3_r)));
  assign busy      = s2_valid || s3_valid;

endmodule

FILE: rtl/point_in_polygon_test.sv
// Top level of the point-in-polygon ray casting block: vertex table and query sequencer.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): each beat is a command. cmd = write stores
//   (coord_x, coord_y) into vertex slot vertex_index and gives no result. cmd =
//   query tests the point (coord_x, coord_y) against the polygon made of vertices
//   0 .. vertex_count-1 and gives one result beat.
//   Output channel (out_valid/out_ready): inside_res (odd crossing count) and
//   crossings. A waiting result does not block vertex writes.
//   Config channel (cfg_valid/cfg_ready): cfg_data sets vertex_count; counts above
//   64 act as 64. Write it only while no query is in flight.
// Query sequence
//   A query walks the table through one read port, one vertex per cycle, reading
//   n+1 entries (vertex 0 again at the end to close the polygon), so edges are
//   tested one per cycle. The reads, the registered read port, the edge-test stages
//   (differences, then cross products) and the result load lie between the query
//   beat and out_valid. A new item is taken only in idle, so queries never overlap.
// Reset
//   vertex_count returns to 3; the table holds no defined contents until written.
// Stall
//   If out_ready is low, the finished query waits in the output register; a
//   second query then completes its walk and holds until that register frees.

module point_in_polygon_test import pip_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         cmd,
  input  logic [5:0]   vertex_index,
  input  coord_t       coord_x,
  input  coord_t       coord_y,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         inside_res,
  output logic [6:0]   crossings
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state;
  count_t     vertex_count;
  count_t     n_used;       // clamped vertex count of the running query
  count_t     rd_cnt;       // reads issued so far
  count_t     hit_cnt;
  coord_t     qx, qy;

  // vertex table: {x, y} per entry, one write port, one registered read port
  logic [2*COORD_W-1:0] vtab [MAX_VERTICES];
  logic [2*COORD_W-1:0] vtab_q;
  logic                 wr_en, rd_en;
  addr_t                rd_addr;
  logic                 rd_valid, rd_first;
  coord_t               prev_x, prev_y, cur_x, cur_y;

  logic                 in_fire, done;
  logic                 hit_valid, hit, edge_busy;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign wr_en     = in_fire && (cmd == CMD_WRITE);
  assign rd_en     = (state == ST_RUN);
  // last read goes back to vertex 0 to close the polygon
  assign rd_addr   = (rd_cnt == n_used) ? '0 : rd_cnt[ADDR_W-1:0];
  assign cur_x     = vtab_q[2*COORD_W-1:COORD_W];
  assign cur_y     = vtab_q[COORD_W-1:0];
  assign done      = (state == ST_DRAIN) && !rd_valid && !edge_busy &&
                     (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vtab[vertex_index] <= {coord_x, coord_y};
    end
    if (rd_en) begin
      vtab_q <= vtab[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= count_t'(3);
      rd_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      rd_valid <= rd_en;
      unique case (state)
        ST_IDLE: begin
          if (in_fire && (cmd == CMD_QUERY)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (rd_cnt == n_used) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (cmd == CMD_QUERY)) begin
      qx      <= coord_x;
      qy      <= coord_y;
      rd_cnt  <= '0;
      hit_cnt <= '0;
      n_used  <= (vertex_count > count_t'(MAX_VERTICES)) ? count_t'(MAX_VERTICES)
                                                         : vertex_count;
    end else begin
      if (rd_en) begin
        rd_cnt <= rd_cnt + count_t'(1);
      end
      if (hit_valid && hit) begin
        hit_cnt <= hit_cnt + count_t'(1);
      end
    end
    rd_first <= (rd_cnt == '0);
    if (rd_valid) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    if (done) begin
      crossings  <= hit_cnt;
      inside_res <= hit_cnt[0];
    end
  end

  // each read after the first closes an edge from the previous vertex
  pip_edge u_edge (
    .clk        (clk),
    .rst        (rst),
    .edge_valid (rd_valid && !rd_first),
    .x1         (prev_x),
    .y1         (prev_y),
    .x2         (cur_x),
    .y2         (cur_y),
    .px         (qx),
    .py         (qy),
    .hit_valid  (hit_valid),
    .hit        (hit),
    .busy       (edge_busy)
  );

endmodule
